### design/assert_macros.svh
// Assertion macros used by the top design file.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check prop at every clock edge outside reset.
`define PMT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check prop at every clock edge, reset included.
`define PMT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PMT_ASSERT(lbl, clk, rst, prop, msg)
`define PMT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### design/pmt_pkg.sv
`timescale 1ns / 1ps

package pmt_pkg;

  localparam int POS_BITS     = 12;
  localparam int CFG_BITS     = 13;
  localparam int BUTTON_COUNT = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] SYNC_BIT    = 8'h08;
  localparam logic [7:0] BUTTON_MASK = 8'h07;

  // Configuration register indexes
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    EV_MOVE = 2'd0,
    EV_DOWN = 2'd1,
    EV_UP   = 2'd2
  } event_kind_t;

  // One decoded packet waiting for its events to go out
  typedef struct packed {
    logic                          moved;
    logic [BUTTON_COUNT-1:0]       changed;
    logic [BUTTON_COUNT-1:0]       buttons;
    logic [POS_BITS-1:0]           pos_x;
    logic [POS_BITS-1:0]           pos_y;
    logic signed [7:0]             dx;
    logic signed [8:0]             dy;
  } pkt_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### design/ps2_mouse_packet_tracker.sv
// PS/2 mouse packet tracker. Bytes from the mouse enter on the rx channel, one beat per
// byte; a byte at packet start without bit 3 set is dropped to regain framing. Every third
// byte closes a packet: the X delta and the negated Y delta move the cursor, which starts
// at 0,0 and is clamped to the screen set by screen_width (register 0) and screen_height
// (register 1); a size of 0 acts as 1 and sizes above 4096 act as 4096. A closed packet
// yields up to four event beats: a move if the position changed, then a down or up for
// each button that flipped, in button order, the final one marked by last_event; a packet
// with no change yields nothing. Bytes may arrive every cycle; the front decodes and
// updates the cursor in the cycle of the closing byte and parks the packet in a two-entry
// queue, from which the event sequencer sends one event per cycle while the receiver is
// ready. A closing byte waits only while both queue entries are occupied. Write the
// registers only while the block is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ps2_mouse_packet_tracker import pmt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          event_kind,
  output logic [POS_BITS-1:0] pos_x,
  output logic [POS_BITS-1:0] pos_y,
  output logic signed [7:0]   delta_x,
  output logic signed [8:0]   delta_y,
  output logic [1:0]          button_index,
  output logic                last_event
);

  logic [CFG_BITS-1:0] screen_width;
  logic [CFG_BITS-1:0] screen_height;

  q_status_t q_status;
  logic      push;
  pkt_t      push_pkt;
  logic      pop;
  pkt_t      head;
  logic      head_valid;

  // Screen size registers; hold their value until rewritten
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= CFG_BITS'(1024);
      screen_height <= CFG_BITS'(768);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: frame bytes, advance the cursor, classify what changed
  pmt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .q_status      (q_status),
    .push          (push),
    .push_pkt      (push_pkt)
  );

  // Short queue of decoded packets between front and back
  pmt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_pkt   (push_pkt),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .status     (q_status)
  );

  // Back: drain each packet as a run of event beats
  pmt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .delta_x      (delta_x),
    .delta_y      (delta_y),
    .button_index (button_index),
    .last_event   (last_event)
  );

  // A packet's run of events ends only with its last beat
  `PMT_ASSERT(a_run_continues, clk, rst, out_valid && !last_event |=> out_valid, "event run broken before its last beat")
  // Move events name no button
  `PMT_ASSERT(a_move_no_button, clk, rst, out_valid && (event_kind == EV_MOVE) |-> (button_index == 2'd0), "move event with a button index")
  // The front never pushes into a full queue
  `PMT_ASSERT(a_no_overflow, clk, rst, push |-> !q_status.full, "packet pushed into a full queue")
  // Nothing leaves straight after reset
  `PMT_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "event beat right after reset")

endmodule

### design/pmt_front.sv
`timescale 1ns / 1ps

module pmt_front import pmt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  input  logic [CFG_BITS-1:0] screen_width,
  input  logic [CFG_BITS-1:0] screen_height,
  input  q_status_t           q_status,
  output logic                push,
  output pkt_t                push_pkt
);

  localparam int SUM_BITS = POS_BITS + 2;
  localparam int POS_TOP  = 1 << POS_BITS;

  typedef enum logic [2:0] {
    PH_SYNC = 3'b001,
    PH_DX   = 3'b010,
    PH_DY   = 3'b100
  } phase_t;

  phase_t                  phase;
  logic [BUTTON_COUNT-1:0] held_buttons_byte;
  logic [7:0]              held_dx_byte;
  logic [POS_BITS-1:0]     cursor_x;
  logic [POS_BITS-1:0]     cursor_y;
  logic [BUTTON_COUNT-1:0] prev_buttons;

  logic                    accept;
  logic [POS_BITS-1:0]     lim_x;
  logic [POS_BITS-1:0]     lim_y;
  logic signed [8:0]       dx_ext;
  logic signed [8:0]       dy;
  logic [POS_BITS-1:0]     cursor_x_next;
  logic [POS_BITS-1:0]     cursor_y_next;
  logic [BUTTON_COUNT-1:0] changed;
  logic                    moved;

  function automatic logic [POS_BITS-1:0] axis_limit(input logic [CFG_BITS-1:0] size);
    logic [POS_BITS-1:0] lim;
    if (size == '0) begin
      lim = '0;
    end else if (32'(size) > POS_TOP) begin
      lim = '1;
    end else begin
      lim = POS_BITS'(size - CFG_BITS'(1));
    end
    return lim;
  endfunction

  function automatic logic [POS_BITS-1:0] clamp_axis(input logic [POS_BITS-1:0] cur,
                                                     input logic signed [8:0] d,
                                                     input logic [POS_BITS-1:0] lim);
    logic signed [SUM_BITS-1:0] n;
    logic [POS_BITS-1:0]        r;
    n = $signed({2'b00, cur}) + SUM_BITS'(d);
    if (n < 0) begin
      r = '0;
    end else if (n > $signed({2'b00, lim})) begin
      r = lim;
    end else begin
      r = n[POS_BITS-1:0];
    end
    return r;
  endfunction

  // Only the closing byte needs queue space
  assign in_ready = (phase != PH_DY) || !q_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    lim_x         = axis_limit(screen_width);
    lim_y         = axis_limit(screen_height);
    dx_ext        = $signed({held_dx_byte[7], held_dx_byte});
    dy            = -$signed({rx_byte[7], rx_byte});
    cursor_x_next = clamp_axis(cursor_x, dx_ext, lim_x);
    cursor_y_next = clamp_axis(cursor_y, dy, lim_y);
    moved         = (cursor_x_next != cursor_x) || (cursor_y_next != cursor_y);
    changed       = held_buttons_byte ^ prev_buttons;
  end

  assign push = accept && (phase == PH_DY) && (moved || (changed != '0));

  always_comb begin
    push_pkt.moved   = moved;
    push_pkt.changed = changed;
    push_pkt.buttons = held_buttons_byte;
    push_pkt.pos_x   = cursor_x_next;
    push_pkt.pos_y   = cursor_y_next;
    push_pkt.dx      = $signed(held_dx_byte);
    push_pkt.dy      = dy;
  end

  // Held bytes carry no reset: always written before the closing byte reads them
  always_ff @(posedge clk) begin
    if (accept) begin
      case (phase)
        PH_SYNC: if ((rx_byte & SYNC_BIT) != '0) begin
          held_buttons_byte <= rx_byte[BUTTON_COUNT-1:0] & BUTTON_MASK[BUTTON_COUNT-1:0];
        end
        PH_DX:   held_dx_byte <= rx_byte;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC;
      cursor_x     <= '0;
      cursor_y     <= '0;
      prev_buttons <= '0;
    end else if (accept) begin
      case (phase)
        PH_SYNC: if ((rx_byte & SYNC_BIT) != '0) begin
          phase <= PH_DX;
        end
        PH_DX:   phase <= PH_DY;
        PH_DY: begin
          phase        <= PH_SYNC;
          cursor_x     <= cursor_x_next;
          cursor_y     <= cursor_y_next;
          prev_buttons <= held_buttons_byte;
        end
        default: phase <= PH_SYNC;
      endcase
    end
  end

endmodule

### design/pmt_queue.sv
`timescale 1ns / 1ps

module pmt_queue import pmt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pkt_t      push_pkt,
  input  logic      pop,
  output pkt_t      head,
  output logic      head_valid,
  output q_status_t status
);

  pkt_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign status.full  = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head_valid   = !status.empty;
  assign head         = slots[rd_ptr];

  assign do_push = push && !status.full;
  assign do_pop  = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/pmt_back.sv
`timescale 1ns / 1ps

module pmt_back import pmt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  pkt_t                head,
  input  logic                head_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          event_kind,
  output logic [POS_BITS-1:0] pos_x,
  output logic [POS_BITS-1:0] pos_y,
  output logic signed [7:0]   delta_x,
  output logic signed [8:0]   delta_y,
  output logic [1:0]          button_index,
  output logic                last_event
);

  localparam int EV_BITS = BUTTON_COUNT + 1;

  logic [EV_BITS-1:0] done;
  logic [EV_BITS-1:0] pending;
  logic [EV_BITS-1:0] sel;
  logic               last;
  logic               load;
  event_kind_t        kind_next;
  logic [1:0]         index_next;

  // Bit 0 is the move event, bit i+1 is button i
  assign pending = {head.changed, head.moved} & ~done;

  always_comb begin
    sel = '0;
    for (int i = EV_BITS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel = '0;
        sel[i] = 1'b1;
      end
    end
  end

  always_comb begin
    kind_next  = EV_MOVE;
    index_next = '0;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (sel[i+1]) begin
        kind_next  = head.buttons[i] ? EV_DOWN : EV_UP;
        index_next = 2'(i);
      end
    end
  end

  assign last = ((pending & ~sel) == '0);
  assign load = head_valid && (pending != '0) && (!out_valid || out_ready);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (load) begin
      event_kind   <= kind_next;
      pos_x        <= head.pos_x;
      pos_y        <= head.pos_y;
      delta_x      <= head.dx;
      delta_y      <= head.dy;
      button_index <= index_next;
      last_event   <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        done      <= last ? '0 : (done | sel);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### sim/tb_ps2_mouse_packet_tracker.sv
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_tracker;
  import pmt_pkg::*;

  // Cycles with no beat on either channel before the run is called dead
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to let pass once the last event is in, before touching registers
  localparam int SETTLE_CYCLES = 10;
  // Long receiver hold-off, enough to fill the event queue and stall rx
  localparam int HOLD_OFF_CYCLES = 80;
  // Bytes per random phase that the block actually takes
  localparam int PHASE_BYTES = 56;

  // One event beat as the block should send it
  typedef struct packed {
    event_kind_t         kind;
    logic [POS_BITS-1:0] x;
    logic [POS_BITS-1:0] y;
    logic [7:0]          dx;
    logic [8:0]          dy;
    logic [1:0]          btn;
    logic                tail;
  } mouse_event_t;

  // Directed row: one rx byte, and where the packet's single event is obvious,
  // that event typed in by hand
  typedef struct packed {
    logic [7:0]   b;
    logic         typed;
    mouse_event_t ev;
  } stim_row_t;

  localparam mouse_event_t NO_EVENT = '0;

  localparam stim_row_t DIRECTED [23] = '{
    // resync: bytes without the sync bit at packet start are dropped
    '{8'h00, 1'b0, NO_EVENT},
    '{8'hF7, 1'b0, NO_EVENT},
    // largest positive dx, most negative dy byte (dy becomes +128)
    '{8'h08, 1'b0, NO_EVENT},
    '{8'h7F, 1'b0, NO_EVENT},
    '{8'h80, 1'b1, '{EV_MOVE, 12'd127, 12'd128, 8'h7F, 9'h080, 2'd0, 1'b1}},
    // press button 0 without moving
    '{8'h09, 1'b0, NO_EVENT},
    '{8'h00, 1'b0, NO_EVENT},
    '{8'h00, 1'b1, '{EV_DOWN, 12'd127, 12'd128, 8'h00, 9'h000, 2'd0, 1'b1}},
    // most negative dx clamps x at 0; buttons 1 and 2 go down
    '{8'h0F, 1'b0, NO_EVENT},
    '{8'h80, 1'b0, NO_EVENT},
    '{8'h7F, 1'b0, NO_EVENT},
    // packet with no change at all: no event
    '{8'h0F, 1'b0, NO_EVENT},
    '{8'h00, 1'b0, NO_EVENT},
    '{8'h00, 1'b0, NO_EVENT},
    // overflow and sign bits set in the head; move plus all three buttons up
    '{8'hF8, 1'b0, NO_EVENT},
    '{8'h01, 1'b0, NO_EVENT},
    '{8'hFF, 1'b0, NO_EVENT},
    // clamp x at the left edge
    '{8'h08, 1'b0, NO_EVENT},
    '{8'h80, 1'b0, NO_EVENT},
    '{8'h00, 1'b1, '{EV_MOVE, 12'd0, 12'd2, 8'h80, 9'h000, 2'd0, 1'b1}},
    // clamp y at the top edge
    '{8'h08, 1'b0, NO_EVENT},
    '{8'h00, 1'b0, NO_EVENT},
    '{8'h7F, 1'b1, '{EV_MOVE, 12'd0, 12'd0, 8'h00, 9'h181, 2'd0, 1'b1}}
  };

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_SCREEN_WIDTH;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          rx_byte = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          event_kind;
  logic [POS_BITS-1:0] pos_x;
  logic [POS_BITS-1:0] pos_y;
  logic signed [7:0]   delta_x;
  logic signed [8:0]   delta_y;
  logic [1:0]          button_index;
  logic                last_event;

  ps2_mouse_packet_tracker u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .delta_x      (delta_x),
    .delta_y      (delta_y),
    .button_index (button_index),
    .last_event   (last_event)
  );

  // Shadow of the block's state, advanced on every accepted rx beat
  logic [1:0]          rx_phase = 2'd0;
  logic [2:0]          held_btn = 3'd0;
  logic [7:0]          held_dx = 8'h00;
  logic [POS_BITS-1:0] cur_x = '0;
  logic [POS_BITS-1:0] cur_y = '0;
  logic [2:0]          btn_state = 3'd0;
  logic [CFG_BITS-1:0] scr_w = CFG_BITS'(1024);
  logic [CFG_BITS-1:0] scr_h = CFG_BITS'(768);

  mouse_event_t due_events[$];
  int           error_count = 0;
  int           bytes_used = 0;
  int           quiet_cycles = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic flag_error(input string what);
    $display("%0t ns: event mismatch: %s", $time, what);
    error_count++;
  endtask

  // Highest legal coordinate on one axis: size 0 acts as 1, oversize saturates
  function automatic logic [POS_BITS-1:0] axis_top(input logic [CFG_BITS-1:0] size);
    if (size == '0) return '0;
    if (size >= CFG_BITS'(1 << POS_BITS)) return '1;
    return size[POS_BITS-1:0] - 1'b1;
  endfunction

  function automatic logic [POS_BITS-1:0] step_axis(input logic [POS_BITS-1:0] cur,
                                                   input int d,
                                                   input logic [POS_BITS-1:0] top);
    int sum;
    sum = int'(cur) + d;
    if (sum < 0) return '0;
    if (sum > int'(top)) return top;
    return sum[POS_BITS-1:0];
  endfunction

  // Advance the shadow state by one rx beat and queue the events it causes.
  // With push clear the state still moves, but the caller supplies the events.
  task automatic track_byte(input logic [7:0] b, input bit push, output bit dropped);
    int                  dxv;
    int                  dyv;
    int                  n;
    int                  i;
    logic [POS_BITS-1:0] nx;
    logic [POS_BITS-1:0] ny;
    logic [2:0]          flipped;
    mouse_event_t        evs [4];
    dropped = 1'b0;
    n = 0;
    if (rx_phase == 2'd0) begin
      if ((b & SYNC_BIT) == '0) begin
        dropped = 1'b1;
      end else begin
        held_btn = 3'(b & BUTTON_MASK);
        rx_phase = 2'd1;
      end
    end else if (rx_phase == 2'd1) begin
      held_dx = b;
      rx_phase = 2'd2;
    end else begin
      rx_phase = 2'd0;
      dxv = int'($signed(held_dx));
      dyv = -int'($signed(b));
      nx = step_axis(cur_x, dxv, axis_top(scr_w));
      ny = step_axis(cur_y, dyv, axis_top(scr_h));
      flipped = held_btn ^ btn_state;
      if (nx != cur_x || ny != cur_y) begin
        evs[n] = '{EV_MOVE, nx, ny, held_dx, 9'(dyv), 2'd0, 1'b0};
        n++;
      end
      cur_x = nx;
      cur_y = ny;
      btn_state = held_btn;
      // button order 0, 1, 2; each flipped button gives one down or up
      for (i = 0; i < BUTTON_COUNT; i++) begin
        if (flipped[i]) begin
          evs[n] = '{held_btn[i] ? EV_DOWN : EV_UP, nx, ny, held_dx, 9'(dyv), 2'(i), 1'b0};
          n++;
        end
      end
      if (n > 0) evs[n-1].tail = 1'b1;
      if (push) begin
        for (i = 0; i < n; i++) due_events.push_back(evs[i]);
      end
    end
  endtask

  // Offer one rx beat after a random gap; hold it until taken, then predict.
  // Valid is left high on return, so the caller either offers again at once
  // or lowers it through settle.
  task automatic offer_byte(input logic [7:0] b, input bit push);
    int gap;
    bit dropped;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    track_byte(b, push, dropped);
    if (!dropped) bytes_used++;
  endtask

  // Mostly zero, extremes and small steps, so the cursor reaches every edge
  function automatic logic [7:0] pick_delta();
    case ($urandom_range(9))
      0, 1:    return 8'h00;
      2:       return 8'h7F;
      3:       return 8'h80;
      4, 5:    return 8'($urandom_range(8)) - 8'd4;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // A well-formed packet with random content, now and then preceded by a
  // stray byte or cut short, which knocks the framing about
  task automatic offer_packet();
    logic [7:0] head;
    head = 8'($urandom_range(255)) | SYNC_BIT;
    // keep the buttons as they are now and then, for packets with no flip
    if ($urandom_range(4) == 0) head[2:0] = btn_state;
    if ($urandom_range(9) == 0) offer_byte(8'($urandom_range(255)), 1'b1);
    offer_byte(head, 1'b1);
    offer_byte(pick_delta(), 1'b1);
    if ($urandom_range(19) != 0) offer_byte(pick_delta(), 1'b1);
  endtask

  task automatic run_phase(input int quota);
    int start;
    start = bytes_used;
    while (bytes_used - start < quota) offer_packet();
  endtask

  // Drop valid, wait for every due event, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both screen registers on back-to-back edges, enable held high
  task automatic set_screen(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    scr_w = w;
    scr_h = h;
  endtask

  // Event side: random stalls, or one long hold-off when asked for
  initial begin : drain_side
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare every event beat with the oldest due event, field by field
  always @(posedge clk) begin : event_check
    mouse_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_events.size() == 0) begin
        flag_error("event beat with nothing due");
      end else begin
        want = due_events.pop_front();
        if (event_kind !== want.kind)
          flag_error($sformatf("event_kind %0d, want %0d", event_kind, want.kind));
        if (pos_x !== want.x)
          flag_error($sformatf("pos_x %0d, want %0d", pos_x, want.x));
        if (pos_y !== want.y)
          flag_error($sformatf("pos_y %0d, want %0d", pos_y, want.y));
        if (delta_x !== want.dx)
          flag_error($sformatf("delta_x %0d, want %0d", delta_x, $signed(want.dx)));
        if (delta_y !== want.dy)
          flag_error($sformatf("delta_y %0d, want %0d", delta_y, $signed(want.dy)));
        if (button_index !== want.btn)
          flag_error($sformatf("button_index %0d, want %0d", button_index, want.btn));
        if (last_event !== want.tail)
          flag_error($sformatf("last_event %0d, want %0d", last_event, want.tail));
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_ps2_mouse_packet_tracker: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int i;
    do @(posedge clk); while (rst);

    // Directed table at reset geometry; sender idles lightly, receiver heavily
    send_idle_pct = 25;
    recv_idle_pct = 78;
    for (i = 0; i < 23; i++) begin
      offer_byte(DIRECTED[i].b, !DIRECTED[i].typed);
      if (DIRECTED[i].typed) due_events.push_back(DIRECTED[i].ev);
    end
    settle();

    // Zero width pins x at 0; height far beyond the coordinate range
    set_screen(CFG_BITS'(0), CFG_BITS'(8191));
    run_phase(PHASE_BYTES);
    settle();

    // Swap the idling; widest screen, single row
    send_idle_pct = 78;
    recv_idle_pct = 25;
    set_screen(CFG_BITS'(4096), CFG_BITS'(1));
    run_phase(PHASE_BYTES);
    settle();

    // No idling. Shrink the screen, so the first packet pulls the cursor in,
    // and stall the receiver long enough for the queue to back up onto rx
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_screen(CFG_BITS'(200), CFG_BITS'(150));
    hold_off_req = 1'b1;
    run_phase(PHASE_BYTES);
    settle();

    // Single column, height just past the coordinate range
    set_screen(CFG_BITS'(1), CFG_BITS'(4097));
    run_phase(PHASE_BYTES);
    settle();

    if (error_count == 0) begin
      $display("tb_ps2_mouse_packet_tracker: clean");
    end else begin
      $display("tb_ps2_mouse_packet_tracker: errors");
    end
    $finish;
  end

endmodule
